FILE: rtl/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// shared types, character codes and helpers of the quoted-printable encoder
// ----------------------------------------------------------------------------
`default_nettype none

package qpe_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxChars = 7;
  localparam int unsigned CntW    = 3;
  localparam int unsigned SumW    = 9;

  localparam logic [ByteW-1:0] LineLimitReset = 8'd70;
  localparam logic [ByteW-1:0] ChEquals       = 8'd61;
  localparam logic [ByteW-1:0] ChNewline      = 8'd10;
  localparam logic [ByteW-1:0] ChComma        = 8'd44;
  localparam logic [ByteW-1:0] ChSemicolon    = 8'd59;
  localparam logic [ByteW-1:0] ChDigitZero    = 8'd48;
  localparam logic [ByteW-1:0] ChLetterA      = 8'd65;

  typedef logic [ByteW-1:0] char_t;

  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic [CntW-1:0]      count;
    logic [ByteW-1:0]     column;
  } qpe_seq_t;

  function automatic logic is_safe(input logic [ByteW-1:0] b);
    logic safe;
    safe = 1'b0;
    if ((b inside {[8'd37:8'd90]}) && b != ChEquals && b != ChComma &&
        b != ChSemicolon) begin
      safe = 1'b1;
    end
    if (b inside {[8'd97:8'd126]}) begin
      safe = 1'b1;
    end
    return safe;
  endfunction

  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = ChDigitZero + {4'd0, nib};
    end else begin
      c = ChLetterA + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qpe_in_if.sv
// ----------------------------------------------------------------------------
// qpe_in_if
// text byte channel of the quoted-printable encoder
// ----------------------------------------------------------------------------
`default_nettype none

interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_text;

  modport source (output valid, output data_byte, output start_of_text, input ready);
  modport sink   (input valid, input data_byte, input start_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/qpe_out_if.sv
// ----------------------------------------------------------------------------
// qpe_out_if
// encoded character channel of the quoted-printable encoder
// ----------------------------------------------------------------------------
`default_nettype none

interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/quoted_printable_encoder.sv
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// quoted-printable encoder, one text byte in, one to seven characters out
// ----------------------------------------------------------------------------
// in_ch carries a text byte and a start-of-text flag per request; out_ch
// carries one encoded character per request, with last_of_run set on the
// final character that a byte produces. cfg_we/cfg_wdata write line_limit.
// an accepted byte sits in an input register, then its whole character
// sequence is built combinationally and loaded into a shift register that
// drives out_ch. first character is offered once the byte has passed the
// input register and the shift register; a busy shift register delays it.
// throughput is set by the output: one character per cycle while out_ch is
// ready; a byte gives 1 to 7 characters (1 if safe, 3 if escaped, plus 2
// each for a text start and a soft break); the input register takes the
// next byte while the current one drains, so bytes follow without gaps.
// reset clears the column, empties both stages and sets line_limit to 70.
// when out_ch stalls, the current character holds and in_ch backs up once
// the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_printable_encoder
  import qpe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [ByteW-1:0] cfg_wdata,
  qpe_in_if.sink                in_ch,
  qpe_out_if.source             out_ch
);

  logic [ByteW-1:0]      line_limit_r;
  logic [ByteW-1:0]      column_r;
  logic                  hold_valid_r;
  logic [ByteW-1:0]      hold_byte_r;
  logic                  hold_start_r;
  logic                  busy_r;
  logic [CntW-1:0]       rem_r;
  char_t [MaxChars-1:0]  seq_r;

  qpe_seq_t seq;
  logic     in_take;
  logic     out_take;
  logic     load;

  qpe_build u_build (
    .data_byte     (hold_byte_r),
    .start_of_text (hold_start_r),
    .column        (column_r),
    .line_limit    (line_limit_r),
    .seq           (seq)
  );

  assign out_take = out_ch.valid && out_ch.ready;
  assign load     = hold_valid_r && (!busy_r || (out_take && rem_r == 3'd1));
  assign in_ch.ready = !hold_valid_r || load;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = busy_r;
  assign out_ch.out_char    = seq_r[0];
  assign out_ch.last_of_run = (rem_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LineLimitReset;
    end else if (cfg_we) begin
      line_limit_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_take) begin
      hold_valid_r <= 1'b1;
    end else if (load) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte_r  <= in_ch.data_byte;
      hold_start_r <= in_ch.start_of_text;
    end
  end

  // output shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rem_r    <= '0;
      column_r <= '0;
    end else if (load) begin
      busy_r   <= 1'b1;
      rem_r    <= seq.count;
      column_r <= seq.column;
    end else if (out_take) begin
      busy_r <= (rem_r != 3'd1);
      rem_r  <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq_r <= seq.chars;
    end else if (out_take) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        seq_r[i] <= seq_r[i+1];
      end
      seq_r[MaxChars-1] <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qpe_build.sv
// ----------------------------------------------------------------------------
// qpe_build
// builds the character sequence and next column for one text byte
// ----------------------------------------------------------------------------
`default_nettype none

module qpe_build
  import qpe_pkg::*;
(
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             start_of_text,
  input  wire logic [ByteW-1:0] column,
  input  wire logic [ByteW-1:0] line_limit,
  output qpe_seq_t              seq
);

  logic [CntW-1:0]  n;
  logic [ByteW-1:0] col_base;
  logic [SumW-1:0]  col_sum;
  logic             safe;

  always_comb begin
    seq.chars = '0;
    n         = '0;
    safe      = is_safe(data_byte);
    col_base  = start_of_text ? '0 : column;

    if (start_of_text) begin
      seq.chars[n] = ChEquals;
      n = n + 1'b1;
      seq.chars[n] = ChNewline;
      n = n + 1'b1;
    end

    if (safe) begin
      seq.chars[n] = data_byte;
      n = n + 1'b1;
      col_sum = {1'b0, col_base} + 9'd1;
    end else begin
      seq.chars[n] = ChEquals;
      n = n + 1'b1;
      seq.chars[n] = hex_char(data_byte[7:4]);
      n = n + 1'b1;
      seq.chars[n] = hex_char(data_byte[3:0]);
      n = n + 1'b1;
      col_sum = {1'b0, col_base} + 9'd3;
    end

    if (col_sum > {1'b0, line_limit}) begin
      seq.chars[n] = ChEquals;
      n = n + 1'b1;
      seq.chars[n] = ChNewline;
      n = n + 1'b1;
      seq.column = '0;
    end else begin
      seq.column = col_sum[ByteW-1:0];
    end

    seq.count = n;
  end

endmodule

`default_nettype wire

FILE: sim/qpe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qpe_checker
// watches both channels of the quoted-printable encoder, predicts the
// character stream of every accepted byte and compares it in order
// ----------------------------------------------------------------------------

module qpe_checker
  import qpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  qpe_in_if          in_mon,
  qpe_out_if         out_mon,
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    char_t chr;
    logic  last;
  } qp_char_t;

  qp_char_t   expected_chars[$];
  logic [7:0] line_limit;
  logic [7:0] column;

  function automatic char_t hex_digit(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = ChDigitZero + {4'd0, nib};
    end else begin
      c = ChLetterA + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  task automatic encode_byte(input char_t b, input logic sot);
    char_t      seq [MaxChars];
    int         n;
    logic [8:0] col;
    qp_char_t   item;
    n = 0;
    if (sot) begin
      seq[0] = ChEquals;
      seq[1] = ChNewline;
      n = 2;
      column = 8'd0;
    end
    col = {1'b0, column};
    if ((b >= 8'd37 && b <= 8'd90 && b != ChEquals && b != ChComma && b != ChSemicolon) ||
        (b >= 8'd97 && b <= 8'd126)) begin
      seq[n] = b;
      n = n + 1;
      col = col + 9'd1;
    end else begin
      seq[n]   = ChEquals;
      seq[n+1] = hex_digit(b[7:4]);
      seq[n+2] = hex_digit(b[3:0]);
      n = n + 3;
      col = col + 9'd3;
    end
    // soft break once the column runs past the limit
    if (col > {1'b0, line_limit}) begin
      seq[n]   = ChEquals;
      seq[n+1] = ChNewline;
      n = n + 2;
      col = 9'd0;
    end
    column = col[7:0];
    for (int i = 0; i < n; i++) begin
      item.chr  = seq[i];
      item.last = (i == n - 1);
      expected_chars = {expected_chars, item};
    end
  endtask

  always @(posedge clk) begin : monitor
    qp_char_t want;
    if (!rst_n) begin
      line_limit = LineLimitReset;
      column     = 8'd0;
      mismatches = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we) begin
        line_limit = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: unexpected char %h last %b", $realtime, out_mon.out_char,
                     out_mon.last_of_run);
          end
        end else begin
          want = expected_chars.pop_front();
          if (want.chr !== out_mon.out_char || want.last !== out_mon.last_of_run) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: char exp %h got %h, last exp %b got %b", $realtime, want.chr,
                       out_mon.out_char, want.last, out_mon.last_of_run);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        encode_byte(in_mon.data_byte, in_mon.start_of_text);
      end
    end
    pending = expected_chars.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the quoted-printable encoder: directed edge bytes, then
// random texts over several line limits and idle/stall mixes
// ----------------------------------------------------------------------------

module tb;
  import qpe_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int mismatches;
  int pending;

  qpe_in_if  in_ch ();
  qpe_out_if out_ch ();

  quoted_printable_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  qpe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.data_byte     = b;
    in_ch.start_of_text = sot;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input int esc_pct);
    logic [7:0] b;
    if ($urandom_range(99) < esc_pct) begin
      case ($urandom_range(4))
        0: b = 8'($urandom_range(128, 255));
        1: b = 8'($urandom_range(0, 36));
        2: b = ChEquals;
        3: b = 8'($urandom_range(91, 96));
        default: b = 8'($urandom_range(0, 255));
      endcase
    end else if ($urandom_range(1)) begin
      b = 8'($urandom_range(97, 126));
    end else begin
      b = 8'($urandom_range(37, 90));
    end
    return b;
  endfunction

  task automatic run_phase(input logic [7:0] limit, input int idle, input int stall,
                           input int count, input int esc_pct, input int max_len);
    int sent;
    int len;
    write_limit(limit);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(1, max_len);
        if (len > count - sent) begin
          len = count - sent;
        end
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(esc_pct), i == 0);
        end
        sent = sent + len;
      end else begin
        // stray request with no text start in front
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent = sent + 1;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] edge_bytes [15];
    edge_bytes = '{8'd0, 8'd255, 8'd36, 8'd37, 8'd90, 8'd91, ChEquals, ChComma,
                   ChSemicolon, 8'd96, 8'd97, 8'd126, 8'd127, 8'd128, 8'hE9};
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 8'd0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'd0;
    in_ch.start_of_text = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset limit, every class of byte
    for (int i = 0; i < 15; i++) begin
      send_byte(edge_bytes[i], i == 0);
    end
    send_byte(8'd65, 1'b1);
    write_limit(8'd1);
    send_byte(8'd97, 1'b1);
    send_byte(8'd98, 1'b0);
    send_byte(8'd255, 1'b0);
    write_limit(8'd0);
    send_byte(8'd90, 1'b1);
    send_byte(8'd0, 1'b0);

    run_phase(8'd70, 0, 0, 60, 30, 20);
    run_phase(8'd1, 68, 0, 50, 40, 10);
    write_limit(8'd250);
    hold_req = 1'b1;
    run_phase(8'd250, 0, 68, 60, 30, 40);
    run_phase(8'd0, 35, 35, 40, 40, 8);
    run_phase(8'd255, 0, 0, 120, 90, 120);
    run_phase(8'($urandom_range(1, 250)), 35, 35, 50, 35, 25);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
